// ===== src/kct_pkg.sv =====
package kct_pkg;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    OP_TICK           = 3'd0,
    OP_DIGIT          = 3'd1,
    OP_SELECT_SECONDS = 3'd2,
    OP_START          = 3'd3,
    OP_CLEAR          = 3'd4
  } op_t;

  // Field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned TIME_W    = 14;
  localparam int unsigned MIN_W     = 9;
  localparam int unsigned SEC_W     = 6;
  localparam int unsigned VALUE_W   = 8;

  // Reset value of the ticks-per-second register
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd5000;

  // Divide by sixty: q = (t * RECIP_60) >> RECIP_SHIFT, exact for t < 23831
  localparam int unsigned        RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_60    = 15'd17477;
  localparam int unsigned        RECIP_SHIFT = 20;
  localparam int unsigned        PROD_W      = TIME_W + RECIP_W;

  // Result payload
  typedef struct packed {
    logic [TIME_W-1:0]  remaining_time;
    logic               led_state;
    logic               shown_valid;
    logic [MIN_W-1:0]   shown_minutes;
    logic [SEC_W-1:0]   shown_seconds;
    logic               entry_mode;
    logic [VALUE_W-1:0] entered_minutes;
    logic [VALUE_W-1:0] entered_seconds;
  } result_t;

endpackage

// ===== src/kct_in_if.sv =====
interface kct_in_if;
  logic                            valid;
  logic                            ready;
  logic [kct_pkg::OP_W-1:0]        operation;
  logic [kct_pkg::DIGIT_W-1:0]     digit;

  modport source (output valid, output operation, output digit, input ready);
  modport sink   (input valid, input operation, input digit, output ready);
endinterface

// ===== src/kct_out_if.sv =====
interface kct_out_if;
  logic                            valid;
  logic                            ready;
  logic [kct_pkg::TIME_W-1:0]      remaining_time;
  logic                            led_state;
  logic                            shown_valid;
  logic [kct_pkg::MIN_W-1:0]       shown_minutes;
  logic [kct_pkg::SEC_W-1:0]       shown_seconds;
  logic                            entry_mode;
  logic [kct_pkg::VALUE_W-1:0]     entered_minutes;
  logic [kct_pkg::VALUE_W-1:0]     entered_seconds;

  modport source (
    output valid, output remaining_time, output led_state, output shown_valid,
    output shown_minutes, output shown_seconds, output entry_mode,
    output entered_minutes, output entered_seconds, input ready
  );
  modport sink (
    input valid, input remaining_time, input led_state, input shown_valid,
    input shown_minutes, input shown_seconds, input entry_mode,
    input entered_minutes, input entered_seconds, output ready
  );
endinterface

// ===== src/keypad_countdown_timer.sv =====
// Countdown timer with keypad entry.
// item_in carries one item per handshake: a timer tick or a key event
// (digit, select seconds, start, clear). result_out returns exactly one
// result item per input item, in order: remaining time, LED level, the
// time shown at a second boundary and the entry state after that item.
// cfg_wr_en/cfg_wr_data write the ticks-per-second count at any edge with
// cfg_wr_en high; write it only while no item is in flight.
// An accepted item sits in the input register, is worked into the result
// register once that register is free, and is offered from then on.
// Throughput: one item per cycle while result_out is ready; input and result
// registers hold one item each and advance whenever the stage ahead is free.
// Divide by sixty is one 14x15 multiply from the time register to the result.
// When result_out stalls, the result register holds, the input register
// fills behind it, and item_in.ready drops only once both are full.
// Reset (rst, synchronous) empties both stages, zeroes the counters, entry
// values, remaining time and LED, and loads 5000 ticks per second.
module keypad_countdown_timer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [kct_pkg::TICKS_W-1:0]  cfg_wr_data,
  kct_in_if.sink                       item_in,
  kct_out_if.source                    result_out
);

  // Configuration
  logic [kct_pkg::TICKS_W-1:0] ticks_per_second;

  // Input register
  logic                         in_valid;
  logic [kct_pkg::OP_W-1:0]     in_op;
  logic [kct_pkg::DIGIT_W-1:0]  in_digit;

  // Timer state
  logic [kct_pkg::TICKS_W-1:0]  tick_count, tick_count_next;
  logic [kct_pkg::TIME_W-1:0]   time_left, time_left_next;
  logic                         mode_flag, mode_flag_next;
  logic [kct_pkg::VALUE_W-1:0]  minutes_value, minutes_value_next;
  logic [kct_pkg::VALUE_W-1:0]  seconds_value, seconds_value_next;
  logic                         led_level, led_level_next;

  // Result register
  logic                         res_valid;
  kct_pkg::result_t             res, res_next;

  // Handshake between stages
  logic res_free;
  logic work_en;

  // Datapath intermediates
  logic [kct_pkg::TICKS_W-1:0]  tick_inc;
  logic                         boundary;
  logic [kct_pkg::VALUE_W-1:0]  entry_cur;
  logic [kct_pkg::VALUE_W-1:0]  entry_new;
  logic [kct_pkg::TIME_W-1:0]   start_value;
  logic [kct_pkg::PROD_W-1:0]   recip_prod;
  logic [kct_pkg::MIN_W-1:0]    div_min;
  logic [kct_pkg::TIME_W-1:0]   min_times_60;
  logic [kct_pkg::TIME_W-1:0]   sec_full;

  assign res_free     = !res_valid || result_out.ready;
  assign work_en      = in_valid && res_free;
  assign item_in.ready = !in_valid || res_free;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= kct_pkg::TICKS_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  // Input register: load on accept, empty when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      in_valid <= 1'b1;
    end else if (work_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_op    <= item_in.operation;
      in_digit <= item_in.digit;
    end
  end

  // Tick count and second boundary
  assign tick_inc = tick_count + {{(kct_pkg::TICKS_W-1){1'b0}}, 1'b1};
  assign boundary = (tick_inc == ticks_per_second);

  // Digit entry: value * 10 + digit, wrapping
  assign entry_cur = mode_flag ? seconds_value : minutes_value;
  assign entry_new = (entry_cur << 3) + (entry_cur << 1)
                   + {{(kct_pkg::VALUE_W-kct_pkg::DIGIT_W){1'b0}}, in_digit};

  // Start load: minutes * 60 + seconds
  assign start_value =
      ({{(kct_pkg::TIME_W-kct_pkg::VALUE_W){1'b0}}, minutes_value} << 6)
    - ({{(kct_pkg::TIME_W-kct_pkg::VALUE_W){1'b0}}, minutes_value} << 2)
    + {{(kct_pkg::TIME_W-kct_pkg::VALUE_W){1'b0}}, seconds_value};

  // Split remaining time into minutes and seconds by reciprocal multiply
  assign recip_prod = {{kct_pkg::RECIP_W{1'b0}}, time_left}
                    * {{kct_pkg::TIME_W{1'b0}}, kct_pkg::RECIP_60};
  assign div_min    = recip_prod[kct_pkg::RECIP_SHIFT +: kct_pkg::MIN_W];
  assign min_times_60 =
      ({{(kct_pkg::TIME_W-kct_pkg::MIN_W){1'b0}}, div_min} << 6)
    - ({{(kct_pkg::TIME_W-kct_pkg::MIN_W){1'b0}}, div_min} << 2);
  assign sec_full   = time_left - min_times_60;

  // Next state and result for the item in the input register
  always_comb begin
    tick_count_next    = tick_count;
    time_left_next     = time_left;
    mode_flag_next     = mode_flag;
    minutes_value_next = minutes_value;
    seconds_value_next = seconds_value;
    led_level_next     = led_level;
    res_next           = '0;

    unique case (in_op)
      kct_pkg::OP_TICK: begin
        tick_count_next = tick_inc;
        if (boundary) begin
          if (time_left != '0) begin
            res_next.shown_valid   = 1'b1;
            res_next.shown_minutes = div_min;
            res_next.shown_seconds = sec_full[kct_pkg::SEC_W-1:0];
            time_left_next = time_left - {{(kct_pkg::TIME_W-1){1'b0}}, 1'b1};
          end
          led_level_next  = !led_level;
          tick_count_next = '0;
        end
      end
      kct_pkg::OP_DIGIT: begin
        if (mode_flag) begin
          seconds_value_next = entry_new;
        end else begin
          minutes_value_next = entry_new;
        end
      end
      kct_pkg::OP_SELECT_SECONDS: begin
        mode_flag_next = 1'b1;
      end
      kct_pkg::OP_START: begin
        time_left_next = start_value;
      end
      kct_pkg::OP_CLEAR: begin
        mode_flag_next     = 1'b0;
        minutes_value_next = '0;
        seconds_value_next = '0;
        time_left_next     = '0;
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase

    res_next.remaining_time  = time_left_next;
    res_next.led_state       = led_level_next;
    res_next.entry_mode      = mode_flag_next;
    res_next.entered_minutes = minutes_value_next;
    res_next.entered_seconds = seconds_value_next;
  end

  // Advance timer state on each worked item
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      time_left     <= '0;
      mode_flag     <= 1'b0;
      minutes_value <= '0;
      seconds_value <= '0;
      led_level     <= 1'b0;
    end else if (work_en) begin
      tick_count    <= tick_count_next;
      time_left     <= time_left_next;
      mode_flag     <= mode_flag_next;
      minutes_value <= minutes_value_next;
      seconds_value <= seconds_value_next;
      led_level     <= led_level_next;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work_en) begin
      res <= res_next;
    end
  end

  assign result_out.valid           = res_valid;
  assign result_out.remaining_time  = res.remaining_time;
  assign result_out.led_state       = res.led_state;
  assign result_out.shown_valid     = res.shown_valid;
  assign result_out.shown_minutes   = res.shown_minutes;
  assign result_out.shown_seconds   = res.shown_seconds;
  assign result_out.entry_mode      = res.entry_mode;
  assign result_out.entered_minutes = res.entered_minutes;
  assign result_out.entered_seconds = res.entered_seconds;

  // A shown time is the remaining time just before its decrement
  a_shown_matches_time: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.shown_valid |->
      ({5'd0, res.shown_minutes} * 14'd60 + {8'd0, res.shown_seconds})
        == res.remaining_time + 14'd1)
    else $error("shown time does not match remaining time");

  // A second boundary flips the LED
  a_led_toggles: assert property (@(posedge clk) disable iff (rst)
    work_en && in_op == kct_pkg::OP_TICK && boundary |=>
      led_level != $past(led_level))
    else $error("LED did not toggle at a second boundary");

  // Key events leave the tick count alone
  a_keys_hold_ticks: assert property (@(posedge clk) disable iff (rst)
    !(work_en && in_op == kct_pkg::OP_TICK) |=> $stable(tick_count))
    else $error("tick count moved without a tick");

  // Clear zeroes the entry and the countdown
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    work_en && in_op == kct_pkg::OP_CLEAR |=>
      !mode_flag && minutes_value == '0 && seconds_value == '0 && time_left == '0)
    else $error("clear left state behind");

  // A stalled result must not be overwritten by new work
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result_out.ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule
